// ===== sv/strs_pkg.sv =====
// ----------------------------------------------------------------------------
// strs_pkg
// Shared types and constants for the range-sum segment tree: controller
// states, the command bundle and the status bundle.
// ----------------------------------------------------------------------------
package strs_pkg;

    localparam int unsigned MODE_W  = 1;
    localparam int unsigned LEAF_W  = 10;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned RANGE_W = 11;
    localparam int unsigned SUM_W   = 64;

    localparam logic [MODE_W-1:0] MODE_UPDATE = 1'b0;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_UPD_LEAF,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_QRY_A,
        ST_QRY_B,
        ST_QRY_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic clr_wr;
        logic upd_leaf;
        logic upd_rd;
        logic upd_wr;
        logic qry_a;
        logic qry_b;
        logic qry_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic is_query;
        logic upd_skip;
        logic upd_top;
        logic q_empty;
        logic q_done;
        logic out_busy;
    } t_sts;

endpackage

// ===== sv/strs_ctrl.sv =====
// ----------------------------------------------------------------------------
// strs_ctrl
// Sequencer for the segment tree: clearing pass after reset, the bottom-up
// ancestor walk of an update and the two-pointer walk of a query.
// ----------------------------------------------------------------------------
module strs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  strs_pkg::t_sts  i_sts,
    output strs_pkg::t_cmd  o_cmd
);

    strs_pkg::t_state r_state;
    strs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= strs_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            strs_pkg::ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = strs_pkg::ST_IDLE;
                end
            end
            strs_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = strs_pkg::ST_DISPATCH;
                end
            end
            strs_pkg::ST_DISPATCH: begin
                priority if (i_sts.is_query && i_sts.q_empty) begin
                    n_state = strs_pkg::ST_QRY_OUT;
                end else if (i_sts.is_query) begin
                    n_state = strs_pkg::ST_QRY_A;
                end else if (i_sts.upd_skip) begin
                    n_state = strs_pkg::ST_IDLE;
                end else begin
                    n_state = strs_pkg::ST_UPD_LEAF;
                end
            end
            strs_pkg::ST_UPD_LEAF: begin
                o_cmd.upd_leaf = 1'b1;
                n_state        = strs_pkg::ST_UPD_RD;
            end
            strs_pkg::ST_UPD_RD: begin
                o_cmd.upd_rd = 1'b1;
                n_state      = strs_pkg::ST_UPD_WR;
            end
            strs_pkg::ST_UPD_WR: begin
                o_cmd.upd_wr = 1'b1;
                n_state = i_sts.upd_top ? strs_pkg::ST_IDLE : strs_pkg::ST_UPD_RD;
            end
            strs_pkg::ST_QRY_A: begin
                o_cmd.qry_a = 1'b1;
                n_state = i_sts.q_done ? strs_pkg::ST_QRY_OUT : strs_pkg::ST_QRY_B;
            end
            strs_pkg::ST_QRY_B: begin
                o_cmd.qry_b = 1'b1;
                n_state     = strs_pkg::ST_QRY_A;
            end
            strs_pkg::ST_QRY_OUT: begin
                // hold until the output register is free
                if (!i_sts.out_busy) begin
                    o_cmd.qry_out = 1'b1;
                    n_state       = strs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = strs_pkg::ST_CLEAR;
            end
        endcase
    end

    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == strs_pkg::ST_CLEAR && i_sts.clr_last) |=> (r_state == strs_pkg::ST_IDLE))
        else $error("clearing pass did not end at the last node");

    a_update_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == strs_pkg::ST_UPD_WR && i_sts.upd_top) |=> (r_state == strs_pkg::ST_IDLE))
        else $error("update walk continued past the root");

    a_stall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> (r_state == strs_pkg::ST_IDLE))
        else $error("input opened outside idle");

endmodule

// ===== sv/strs_dpath.sv =====
// ----------------------------------------------------------------------------
// strs_dpath
// Node-sum memory with one write and one registered read port, the item
// registers, node and range pointers, the accumulator and the result register.
// ----------------------------------------------------------------------------
module strs_dpath #(
    parameter int unsigned LEAVES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  strs_pkg::t_cmd                      i_cmd,
    output strs_pkg::t_sts                      o_sts,
    input  logic [strs_pkg::MODE_W-1:0]         i_mode,
    input  logic [strs_pkg::LEAF_W-1:0]         i_leaf_index,
    input  logic signed [strs_pkg::VALUE_W-1:0] i_new_value,
    input  logic [strs_pkg::RANGE_W-1:0]        i_range_lo,
    input  logic [strs_pkg::RANGE_W-1:0]        i_range_hi,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [strs_pkg::SUM_W-1:0]   o_range_sum
);

    localparam int unsigned NODES = 2 * LEAVES;
    localparam int unsigned AW    = $clog2(NODES);
    localparam int unsigned IW    = $clog2(NODES + 1);

    logic [strs_pkg::SUM_W-1:0] r_mem [NODES];
    logic [strs_pkg::SUM_W-1:0] r_rdata;

    logic [AW-1:0]                r_clr_cnt;
    logic [strs_pkg::MODE_W-1:0]  r_mode;
    logic                         r_skip;
    logic                         r_empty;
    logic [AW-1:0]                r_node;
    logic [IW-1:0]                r_left;
    logic [IW-1:0]                r_right;
    logic [strs_pkg::SUM_W-1:0]   r_acc;
    logic                         r_pend;
    logic                         r_out_valid;
    logic [strs_pkg::SUM_W-1:0]   r_out_sum;

    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [strs_pkg::SUM_W-1:0]   wr_data;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;

    logic [31:0]                  lo_ext;
    logic [31:0]                  hi_clamp;
    logic [strs_pkg::SUM_W-1:0]   value_ext;
    logic [strs_pkg::SUM_W-1:0]   sib_sum;
    logic [strs_pkg::SUM_W-1:0]   pend_data;
    logic [IW-1:0]                right_dec;
    logic                         q_done;

    assign lo_ext    = 32'(i_range_lo);
    assign hi_clamp  = (32'(i_range_hi) > LEAVES) ? LEAVES : 32'(i_range_hi);
    assign value_ext = {{(strs_pkg::SUM_W - strs_pkg::VALUE_W){i_new_value[strs_pkg::VALUE_W-1]}},
                        i_new_value};
    assign sib_sum   = r_acc + r_rdata;
    assign pend_data = r_pend ? r_rdata : '0;
    assign right_dec = r_right - IW'(1);
    assign q_done    = !(r_left < r_right);

    // memory port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr_cnt;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = r_left[AW-1:0];
        priority if (i_cmd.clr_wr) begin
            wr_en = 1'b1;
        end else if (i_cmd.upd_leaf) begin
            wr_en   = 1'b1;
            wr_addr = r_node;
            wr_data = r_acc;
        end else if (i_cmd.upd_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_node >> 1;
            wr_data = sib_sum;
        end else if (i_cmd.upd_rd) begin
            rd_en   = 1'b1;
            rd_addr = r_node ^ AW'(1);
        end else if (i_cmd.qry_a) begin
            rd_en   = !q_done && r_left[0];
            rd_addr = r_left[AW-1:0];
        end else if (i_cmd.qry_b) begin
            rd_en   = r_right[0];
            rd_addr = right_dec[AW-1:0];
        end else begin
            rd_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            priority if (i_cmd.load) begin
                r_pend <= 1'b0;
            end else if (i_cmd.qry_a) begin
                r_pend <= !q_done && r_left[0];
            end else if (i_cmd.qry_b) begin
                r_pend <= r_right[0];
            end else begin
                r_pend <= r_pend;
            end
            priority if (i_cmd.qry_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end else begin
                r_out_valid <= r_out_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_skip  <= 32'(i_leaf_index) >= LEAVES;
            r_empty <= lo_ext >= hi_clamp;
            r_node  <= AW'(32'(i_leaf_index) + LEAVES);
            r_left  <= IW'(lo_ext + LEAVES);
            r_right <= IW'(hi_clamp + LEAVES);
        end else if (i_cmd.upd_wr) begin
            r_node <= r_node >> 1;
        end else if (i_cmd.qry_b) begin
            // step both pointers up one level; an odd left has been consumed
            r_left  <= (r_left + IW'(r_left[0])) >> 1;
            r_right <= r_right >> 1;
        end

        priority if (i_cmd.load) begin
            r_acc <= (i_mode == strs_pkg::MODE_UPDATE) ? value_ext : '0;
        end else if (i_cmd.upd_wr) begin
            r_acc <= sib_sum;
        end else if (i_cmd.qry_a || i_cmd.qry_b) begin
            r_acc <= r_acc + pend_data;
        end else begin
            r_acc <= r_acc;
        end

        if (i_cmd.qry_out) begin
            r_out_sum <= r_acc;
        end
    end

    assign o_sts.clr_last = (32'(r_clr_cnt) == NODES - 1);
    assign o_sts.is_query = (r_mode == strs_pkg::MODE_QUERY);
    assign o_sts.upd_skip = r_skip;
    assign o_sts.upd_top  = ((r_node >> 1) == AW'(1));
    assign o_sts.q_empty  = r_empty;
    assign o_sts.q_done   = q_done;
    assign o_sts.out_busy = r_out_valid && i_stall;

    assign o_valid     = r_out_valid;
    assign o_range_sum = r_out_sum;

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.qry_out))
        else $error("result appeared without a query completing");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.qry_out |-> !(r_out_valid && i_stall))
        else $error("stalled result overwritten");

    a_parent_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd_wr |-> (r_node > AW'(1)))
        else $error("ancestor write above the root");

endmodule

// ===== sv/segment_tree_range_sum.sv =====
// ----------------------------------------------------------------------------
// segment_tree_range_sum
// Sum segment tree: point update of a leaf, half-open range sum query.
// ----------------------------------------------------------------------------
// Update: the leaf is written, then one sibling read and one parent write per level
//   up to the root; an update to a leaf index at or beyond LEAVES is dropped.
// Query: both pointers walk up one level per step and the sum is registered to
//   o_valid; an empty range skips the walk. The input reopens as o_valid rises.
// One item in flight at a time; reset is synchronous, then a clearing pass over all
//   2*LEAVES nodes zeroes the node memory while the input is stalled.
module segment_tree_range_sum #(
    parameter int unsigned LEAVES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [strs_pkg::MODE_W-1:0]         i_mode,
    input  logic [strs_pkg::LEAF_W-1:0]         i_leaf_index,
    input  logic signed [strs_pkg::VALUE_W-1:0] i_new_value,
    input  logic [strs_pkg::RANGE_W-1:0]        i_range_lo,
    input  logic [strs_pkg::RANGE_W-1:0]        i_range_hi,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [strs_pkg::SUM_W-1:0]   o_range_sum
);

    strs_pkg::t_cmd cmd;
    strs_pkg::t_sts sts;

    strs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    strs_dpath #(
        .LEAVES (LEAVES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_mode       (i_mode),
        .i_leaf_index (i_leaf_index),
        .i_new_value  (i_new_value),
        .i_range_lo   (i_range_lo),
        .i_range_hi   (i_range_hi),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_range_sum  (o_range_sum)
    );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the range-sum segment tree. A leaf-value shadow
// array predicts every query; each query sum is queued in order and compared
// with the next accepted o_range_sum. Directed cases cover value and range
// extremes, then random update/query traffic runs under three idle mixes and
// one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned LEAVES = 1024;

    logic                                i_clk        = 1'b0;
    logic                                i_rst_n      = 1'b0;
    logic                                i_valid      = 1'b0;
    logic                                o_stall;
    logic [strs_pkg::MODE_W-1:0]         i_mode       = strs_pkg::MODE_UPDATE;
    logic [strs_pkg::LEAF_W-1:0]         i_leaf_index = '0;
    logic signed [strs_pkg::VALUE_W-1:0] i_new_value  = '0;
    logic [strs_pkg::RANGE_W-1:0]        i_range_lo   = '0;
    logic [strs_pkg::RANGE_W-1:0]        i_range_hi   = '0;
    logic                                o_valid;
    logic                                i_stall      = 1'b0;
    logic signed [strs_pkg::SUM_W-1:0]   o_range_sum;

    // shadow of the leaf values; unwritten leaves are zero after reset
    logic signed [strs_pkg::SUM_W-1:0] leaf_vals [0:LEAVES-1];
    // predicted sums in query order
    logic signed [strs_pkg::SUM_W-1:0] sum_fifo [0:1023];
    logic [9:0]                        sum_wr_ptr = '0;
    logic [9:0]                        sum_rd_ptr = '0;
    logic signed [strs_pkg::SUM_W-1:0] want_sum;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_off      = 1'b0;
    int          errors        = 0;

    segment_tree_range_sum #(
        .LEAVES(LEAVES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_leaf_index(i_leaf_index),
        .i_new_value (i_new_value),
        .i_range_lo  (i_range_lo),
        .i_range_hi  (i_range_hi),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_range_sum (o_range_sum)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver stall: random idling, or a forced hold-off
    always @(negedge i_clk) begin
        i_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
    end

    // compare each accepted result with the oldest predicted sum
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (sum_wr_ptr == sum_rd_ptr) begin
                errors++;
                $display("%0t: unexpected range_sum, expected none, actual %0d",
                         $time, o_range_sum);
            end else begin
                want_sum   = sum_fifo[sum_rd_ptr];
                sum_rd_ptr = sum_rd_ptr + 10'(1);
                if (o_range_sum !== want_sum) begin
                    errors++;
                    $display("%0t: range_sum mismatch, expected %0d, actual %0d",
                             $time, want_sum, o_range_sum);
                end
            end
        end
    end

    function automatic logic signed [strs_pkg::SUM_W-1:0] leaf_range_total(int unsigned lo,
                                                                           int unsigned hi);
        logic signed [strs_pkg::SUM_W-1:0] acc;
        acc = '0;
        if (hi > LEAVES) begin
            hi = LEAVES;
        end
        for (int unsigned k = lo; k < hi; k++) begin
            acc += leaf_vals[k];
        end
        return acc;
    endfunction

    // drive one transaction at the falling edge, wait for it to be taken,
    // then fold it into the shadow state
    task automatic send_item(logic [strs_pkg::MODE_W-1:0] mode,
                             logic [strs_pkg::LEAF_W-1:0] leaf,
                             logic signed [strs_pkg::VALUE_W-1:0] value,
                             logic [strs_pkg::RANGE_W-1:0] lo,
                             logic [strs_pkg::RANGE_W-1:0] hi);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid      <= 1'b0;
            i_mode       <= strs_pkg::MODE_W'($urandom_range(0, 1));
            i_leaf_index <= strs_pkg::LEAF_W'($urandom);
            i_new_value  <= strs_pkg::VALUE_W'($urandom);
            i_range_lo   <= strs_pkg::RANGE_W'($urandom);
            i_range_hi   <= strs_pkg::RANGE_W'($urandom);
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_leaf_index <= leaf;
        i_new_value  <= value;
        i_range_lo   <= lo;
        i_range_hi   <= hi;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        if (mode == strs_pkg::MODE_UPDATE) begin
            if (leaf < LEAVES) begin
                leaf_vals[leaf] = strs_pkg::SUM_W'(value);
            end
        end else begin
            sum_fifo[sum_wr_ptr] = leaf_range_total(lo, hi);
            sum_wr_ptr           = sum_wr_ptr + 10'(1);
        end
    endtask

    // unused fields carry junk: the block must ignore them
    task automatic send_update(logic [strs_pkg::LEAF_W-1:0] leaf,
                               logic signed [strs_pkg::VALUE_W-1:0] value);
        send_item(strs_pkg::MODE_UPDATE, leaf, value,
                  strs_pkg::RANGE_W'($urandom), strs_pkg::RANGE_W'($urandom));
    endtask

    task automatic send_query(logic [strs_pkg::RANGE_W-1:0] lo,
                              logic [strs_pkg::RANGE_W-1:0] hi);
        send_item(strs_pkg::MODE_QUERY, strs_pkg::LEAF_W'($urandom),
                  strs_pkg::VALUE_W'($urandom), lo, hi);
    endtask

    function automatic logic [strs_pkg::LEAF_W-1:0] pick_leaf();
        case ($urandom_range(0, 3))
            0:       return strs_pkg::LEAF_W'($urandom_range(0, 15));
            1:       return strs_pkg::LEAF_W'($urandom_range(LEAVES - 16, LEAVES - 1));
            default: return strs_pkg::LEAF_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [strs_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(strs_pkg::VALUE_W-1){1'b0}}};
            1:       return {1'b0, {(strs_pkg::VALUE_W-1){1'b1}}};
            2:       return -1;
            3:       return 0;
            default: return strs_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    task automatic send_random_item();
        int unsigned lo;
        int unsigned hi;
        if ($urandom_range(0, 99) < 40) begin
            send_update(pick_leaf(), pick_value());
        end else begin
            case ($urandom_range(0, 9))
                0: begin
                    lo = $urandom_range(0, 2047);
                    hi = $urandom_range(0, 2047);
                end
                1: begin
                    lo = $urandom_range(0, LEAVES);
                    hi = lo;
                end
                2: begin
                    hi = $urandom_range(0, LEAVES - 1);
                    lo = $urandom_range(hi + 1, LEAVES);
                end
                default: begin
                    lo = $urandom_range(0, LEAVES);
                    hi = $urandom_range(lo, LEAVES);
                end
            endcase
            send_query(strs_pkg::RANGE_W'(lo), strs_pkg::RANGE_W'(hi));
        end
    endtask

    task automatic test_cleared_tree();
        send_query(0, strs_pkg::RANGE_W'(LEAVES));
        send_query(strs_pkg::RANGE_W'(LEAVES - 1), strs_pkg::RANGE_W'(LEAVES));
    endtask

    task automatic test_value_extremes();
        send_update(0, {1'b1, {(strs_pkg::VALUE_W-1){1'b0}}});
        send_update(strs_pkg::LEAF_W'(LEAVES - 1), {1'b0, {(strs_pkg::VALUE_W-1){1'b1}}});
        send_update(512, -1);
        send_update(1, {1'b1, {(strs_pkg::VALUE_W-1){1'b0}}});
        send_update(2, {1'b1, {(strs_pkg::VALUE_W-1){1'b0}}});
        send_query(0, strs_pkg::RANGE_W'(LEAVES));
        send_query(0, 3);
        send_query(strs_pkg::RANGE_W'(LEAVES - 1), strs_pkg::RANGE_W'(LEAVES));
        // overwrite a leaf and check the ancestors follow
        send_update(1, 12345);
        send_query(0, 2);
    endtask

    task automatic test_range_edges();
        send_query(0, 1);
        send_query(0, 0);
        send_query(700, 300);
        send_query(strs_pkg::RANGE_W'(LEAVES), strs_pkg::RANGE_W'(LEAVES));
        send_query(0, 2047);
        send_query(2047, 2047);
        send_query(1500, 2000);
        send_query(511, 2047);
        send_query(1, strs_pkg::RANGE_W'(LEAVES - 1));
    endtask

    task automatic test_random_traffic(int unsigned count, int unsigned tx_pct,
                                       int unsigned rx_pct);
        send_idle_pct = tx_pct;
        recv_idle_pct = rx_pct;
        repeat (count) begin
            send_random_item();
        end
    endtask

    // hold the output for a long stretch while queries keep coming
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                repeat (15) begin
                    send_query(strs_pkg::RANGE_W'($urandom_range(0, LEAVES / 2)),
                               strs_pkg::RANGE_W'($urandom_range(LEAVES / 2, LEAVES)));
                end
            end
        join
    endtask

    task automatic drain_and_report();
        @(negedge i_clk);
        i_valid       <= 1'b0;
        recv_idle_pct = 0;
        while (sum_wr_ptr != sum_rd_ptr) begin
            @(posedge i_clk);
        end
        // leave room for a stray result
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    endtask

    initial begin
        for (int k = 0; k < LEAVES; k++) begin
            leaf_vals[k] = '0;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_cleared_tree();
        test_value_extremes();
        test_range_edges();
        test_random_traffic(310, 6, 59);
        test_random_traffic(310, 59, 6);
        test_random_traffic(310, 0, 0);
        test_output_backpressure();
        drain_and_report();
    end

    initial begin
        #4_800_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== segment_tree_range_sum.f =====
sv/strs_pkg.sv
sv/strs_ctrl.sv
sv/strs_dpath.sv
sv/segment_tree_range_sum.sv
tb/sv/tb.sv
